// ===== rtl/eps_pkg.sv =====
// Shared types and constants for the encoder PID servo block.
package eps_pkg;

    // Input word: encoder step or control update.
    typedef struct packed {
        logic              action;
        logic signed [7:0]  count_step;
        logic signed [15:0] target;
        logic [15:0]        elapsed_us;
    } in_word_t;

    // Result word: motor direction and PWM duty.
    typedef struct packed {
        logic       direction;
        logic [7:0] duty;
    } out_word_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [1:0] CFG_GAIN_DERIV = 2'd2;
    localparam logic [1:0] CFG_MAX_TARGET = 2'd3;

    // Input action codes.
    localparam logic ACT_ENCODER = 1'b0;
    localparam logic ACT_CONTROL = 1'b1;

    // Register reset values.
    localparam logic [15:0] GAIN_PROP_RST  = 16'd256;
    localparam logic [15:0] GAIN_INTEG_RST = 16'd26;
    localparam logic [15:0] GAIN_DERIV_RST = 16'd128;
    localparam logic [14:0] MAX_TARGET_RST = 15'd1000;

    // Datapath widths.
    localparam int DIFF_W = 33;  // error change, signed
    localparam int MAG_W  = 32;  // magnitude of the error change
    localparam int QUO_W  = 33;  // signed derivative quotient
    localparam int MULA_W = 17;  // shared multiplier, gain side
    localparam int MULB_W = 34;  // shared multiplier, data side
    localparam int PROD_W = MULA_W + MULB_W;
    localparam int INTEG_W = 48;
    localparam int ACC_W  = 66;

endpackage

// ===== rtl/eps_div.sv =====
// Bit-serial restoring divider for the derivative term, one quotient bit per cycle.
module eps_div
    import eps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] dividend,
    input  logic [15:0]              divisor,
    output logic                     done,
    output logic signed [QUO_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(MAG_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      rem_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [15:0]      dsr_reg;
    logic             neg_reg;

    logic [DIFF_W-1:0] abs_dividend;
    logic [16:0]       shifted;
    logic [16:0]       trial;
    logic              fits;
    logic [15:0]       rem_next;
    logic [MAG_W-1:0]  quo_next;

    // Magnitude of the signed dividend; the sign is applied at the end.
    assign abs_dividend = dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);

    // One restoring step: bring down the next bit and try a subtract.
    always_comb begin
        shifted  = {rem_reg, quo_reg[MAG_W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        fits     = (shifted >= {1'b0, dsr_reg});
        rem_next = fits ? trial[15:0] : shifted[15:0];
        quo_next = {quo_reg[MAG_W-2:0], fits};
    end

    // Sequencing of the iterations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // Done pulses for one cycle after the last step.
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= abs_dividend[MAG_W-1:0];
            dsr_reg <= divisor;
            neg_reg <= dividend[DIFF_W-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? QUO_W'(-$signed({1'b0, quo_reg}))
                              : QUO_W'($signed({1'b0, quo_reg}));

endmodule

// ===== rtl/encoder_pid_servo_core.sv =====
// Top level of the encoder PID servo: sequencer, shared multiplier and state.
//
//  channel   direction  ports                         word
//  s_        in         s_valid s_ready s_word        in_word_t
//  m_        out        m_valid m_ready m_word        out_word_t
//  cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  16-bit register
//
// An encoder word updates the count and the block is ready again at once.
// A control word keeps the block busy through S_ERR, S_MUL_EDT, S_INTEG, S_P,
// S_ILO, S_IHI, S_WAIT_DIV, S_D_ACC, S_SAT and S_OUT, which registers the
// result. The 32-step derivative divider sets the wait in S_WAIT_DIV; the
// shared 17x34 multiplier forms its five products in turn, the last from its quotient.
// Reset is synchronous on aresetn low; it clears the count, integral and
// previous error and restores the default gains. A result waiting in the
// output register does not block new words; the block stalls only when a new
// result is due and the previous one has not been taken. Configuration is
// accepted in every cycle.
module encoder_pid_servo_core
    import eps_pkg::*;
#(
    parameter int DUTY_MAX   = 255,
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int EXT_W = (COUNT_BITS > 32) ? COUNT_BITS + 1 : 33;
    localparam logic signed [EXT_W-1:0] E_HI = {{(EXT_W-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [EXT_W-1:0] E_LO = {{(EXT_W-32){1'b1}}, 32'h8000_0000};
    localparam logic [15:0] DUTY_LIM = 16'(DUTY_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_MUL_EDT, S_INTEG, S_P, S_ILO, S_IHI,
        S_WAIT_DIV, S_D_ACC, S_SAT, S_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] gain_prop_reg;
    logic [15:0] gain_integ_reg;
    logic [15:0] gain_deriv_reg;
    logic [14:0] max_target_reg;

    logic signed [COUNT_BITS-1:0] count_reg;
    logic signed [INTEG_W-1:0]    integ_reg;
    logic signed [31:0]           prev_reg;
    logic signed [31:0]           e_reg;
    logic signed [15:0]           tgt_reg;
    logic [15:0]                  dt_reg;
    logic signed [DIFF_W-1:0]     diff_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [55:0]           drive_reg;
    logic                         div_start_reg;
    logic                         out_valid_reg;
    out_word_t                    out_word_reg;

    logic                     accept;
    logic signed [16:0]       tgt_ext;
    logic signed [16:0]       lim_ext;
    logic signed [15:0]       tgt_clamped;
    logic signed [EXT_W-1:0]  err_wide;
    logic signed [31:0]       err_sat;
    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [49:0]       integ_sum;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [63:0]       sum_sat;
    logic [55:0]              drive_mag;
    logic                     div_done;
    logic signed [QUO_W-1:0]  div_quotient;
    logic                     out_free;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_word    = out_word_reg;

    // Target limited to plus or minus max_target.
    always_comb begin
        tgt_ext = 17'(s_word.target);
        lim_ext = $signed({2'b00, max_target_reg});
        if (tgt_ext > lim_ext) begin
            tgt_clamped = lim_ext[15:0];
        end else if (tgt_ext < -lim_ext) begin
            tgt_clamped = 16'(-lim_ext);
        end else begin
            tgt_clamped = s_word.target;
        end
    end

    // Position error, saturated to the signed 32-bit range.
    always_comb begin
        err_wide = EXT_W'(tgt_reg) - EXT_W'(count_reg);
        if (err_wide > E_HI) begin
            err_sat = E_HI[31:0];
        end else if (err_wide < E_LO) begin
            err_sat = E_LO[31:0];
        end else begin
            err_sat = err_wide[31:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_EDT: begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = MULB_W'(e_reg);
            end
            S_INTEG: begin
                mul_a = $signed({1'b0, gain_prop_reg});
                mul_b = MULB_W'(e_reg);
            end
            S_P: begin
                mul_a = $signed({1'b0, gain_integ_reg});
                mul_b = $signed({{(MULB_W-24){1'b0}}, integ_reg[23:0]});
            end
            S_ILO: begin
                mul_a = $signed({1'b0, gain_integ_reg});
                mul_b = MULB_W'($signed(integ_reg[47:24]));
            end
            S_WAIT_DIV: begin
                mul_a = $signed({1'b0, gain_deriv_reg});
                mul_b = MULB_W'(div_quotient);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Integral update, saturated to 48 bits.
    always_comb begin
        integ_sum = 50'(integ_reg) + 50'($signed(prod_reg[47:0]));
        if (integ_sum[49:47] == 3'b000 || integ_sum[49:47] == 3'b111) begin
            integ_next = integ_sum[47:0];
        end else if (integ_sum[49]) begin
            integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    // Drive sum saturated to the signed 64-bit range.
    always_comb begin
        if (acc_reg[65:63] == 3'b000 || acc_reg[65:63] == 3'b111) begin
            sum_sat = acc_reg[63:0];
        end else if (acc_reg[65]) begin
            sum_sat = {1'b1, 63'd0};
        end else begin
            sum_sat = {1'b0, {63{1'b1}}};
        end
    end

    assign drive_mag = drive_reg[55] ? 56'(-drive_reg) : 56'(drive_reg);

    // Serial divider for the derivative term.
    eps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (diff_reg),
        .divisor  ((dt_reg == 16'd0) ? 16'd1 : dt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_integ_reg <= GAIN_INTEG_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
            max_target_reg <= MAX_TARGET_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                CFG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                CFG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                CFG_MAX_TARGET: max_target_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Sequencer with the servo state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // The divider starts once the error change is registered.
            div_start_reg <= (state_reg == S_MUL_EDT);
            prod_reg      <= prod_next;
            if (out_valid_reg && m_ready && state_reg != S_OUT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_word.action == ACT_ENCODER) begin
                            count_reg <= count_reg + COUNT_BITS'(s_word.count_step);
                        end else begin
                            tgt_reg   <= tgt_clamped;
                            dt_reg    <= s_word.elapsed_us;
                            state_reg <= S_ERR;
                        end
                    end
                end
                S_ERR: begin
                    e_reg     <= err_sat;
                    state_reg <= S_MUL_EDT;
                end
                S_MUL_EDT: begin
                    diff_reg  <= DIFF_W'(e_reg) - DIFF_W'(prev_reg);
                    prev_reg  <= e_reg;
                    state_reg <= S_INTEG;
                end
                S_INTEG: begin
                    integ_reg <= integ_next;
                    state_reg <= S_P;
                end
                S_P: begin
                    acc_reg   <= ACC_W'(prod_reg);
                    state_reg <= S_ILO;
                end
                S_ILO: begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    state_reg <= S_IHI;
                end
                S_IHI: begin
                    acc_reg   <= acc_reg + $signed({prod_reg[40], prod_reg[40:0], 24'd0});
                    state_reg <= S_WAIT_DIV;
                end
                S_WAIT_DIV: begin
                    if (div_done) begin
                        state_reg <= S_D_ACC;
                    end
                end
                S_D_ACC: begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    state_reg <= S_SAT;
                end
                S_SAT: begin
                    drive_reg <= sum_sat[63:8];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        out_valid_reg          <= 1'b1;
                        out_word_reg.direction <= !drive_reg[55] && (drive_reg != '0);
                        out_word_reg.duty      <= (drive_mag > 56'(DUTY_LIM)) ?
                                                  DUTY_LIM[7:0] : drive_mag[7:0];
                        state_reg              <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // A control word keeps the block busy in the following cycle.
    a_control_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_word.action == ACT_CONTROL |=> !s_ready)
        else $error("block ready right after a control word");

    // An encoder word never raises a result.
    a_encoder_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_word.action == ACT_ENCODER && !m_valid |=> !m_valid)
        else $error("result raised by an encoder word");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_WAIT_DIV)
        else $error("divider finished outside its wait state");

    // A new result comes only from the output state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

endmodule

// ===== verif/eps_servo_checker.sv =====
// Checker for the encoder PID servo: predicts every drive word and compares it with the block.
module eps_servo_checker
    import eps_pkg::*;
#(
    parameter int DUTY_MAX   = 255,
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_word_t    s_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_word_t   m_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          words_waiting
);

    localparam longint ERR_MAX   = 64'sd2147483647;
    localparam longint ERR_MIN   = -ERR_MAX - 1;
    localparam longint INTEG_MAX = (64'sd1 <<< 47) - 1;
    localparam longint INTEG_MIN = -(64'sd1 <<< 47);
    localparam longint LONG_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LONG_MIN  = -LONG_MAX - 1;

    // Shadow copy of the registers and the servo state.
    logic [15:0]           gain_prop;
    logic [15:0]           gain_integ;
    logic [15:0]           gain_deriv;
    logic [14:0]           max_target;
    logic [COUNT_BITS-1:0] position_count;
    longint                error_integral;
    longint                previous_error;

    // Drive words still owed by the block, oldest first.
    out_word_t expected_drive_q[$];
    out_word_t oldest_drive;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Signed 64-bit addition that sticks at the limits instead of wrapping.
    function automatic longint sat_sum(longint a, longint b);
        if (b > 0 && a > LONG_MAX - b) return LONG_MAX;
        if (b < 0 && a < LONG_MIN - b) return LONG_MIN;
        return a + b;
    endfunction

    // One control update: advances the integral and previous error, returns the drive word.
    function automatic out_word_t servo_drive(in_word_t w);
        longint    limit;
        longint    goal;
        longint    err;
        longint    dt;
        longint    deriv;
        longint    sum;
        longint    drive;
        longint    mag;
        out_word_t r;
        limit = longint'(max_target);
        goal  = clamp(longint'(w.target), -limit, limit);
        err   = clamp(goal - longint'($signed(position_count)), ERR_MIN, ERR_MAX);
        dt    = longint'(w.elapsed_us);
        error_integral = clamp(error_integral + err * dt, INTEG_MIN, INTEG_MAX);
        // A zero interval divides by one; the division truncates toward zero.
        deriv = (err - previous_error) / ((dt == 0) ? 64'sd1 : dt);
        previous_error = err;
        sum = longint'(gain_prop) * err;
        sum = sat_sum(sum, longint'(gain_integ) * error_integral);
        sum = sat_sum(sum, longint'(gain_deriv) * deriv);
        drive = sum >>> 8;
        mag   = (drive < 0) ? -drive : drive;
        if (mag > longint'(DUTY_MAX)) mag = longint'(DUTY_MAX);
        r.direction = (drive > 0);
        r.duty      = mag[7:0];
        return r;
    endfunction

    // Results are compared first, then register writes, then new input words.
    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop      = GAIN_PROP_RST;
            gain_integ     = GAIN_INTEG_RST;
            gain_deriv     = GAIN_DERIV_RST;
            max_target     = MAX_TARGET_RST;
            position_count = '0;
            error_integral = 0;
            previous_error = 0;
            fail_count     = 0;
            expected_drive_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_drive_q.size() == 0) begin
                    $error("result word with no control update waiting: direction %0d duty %0d",
                           m_word.direction, m_word.duty);
                    fail_count++;
                end else begin
                    oldest_drive = expected_drive_q.pop_front();
                    if (m_word.direction !== oldest_drive.direction) begin
                        $error("direction: expected %0d, actual %0d",
                               oldest_drive.direction, m_word.direction);
                        fail_count++;
                    end
                    if (m_word.duty !== oldest_drive.duty) begin
                        $error("duty: expected %0d, actual %0d", oldest_drive.duty, m_word.duty);
                        fail_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GAIN_PROP:  gain_prop  = cfg_data;
                    CFG_GAIN_INTEG: gain_integ = cfg_data;
                    CFG_GAIN_DERIV: gain_deriv = cfg_data;
                    CFG_MAX_TARGET: max_target = cfg_data[14:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                if (s_word.action == ACT_CONTROL) begin
                    expected_drive_q.push_back(servo_drive(s_word));
                end else begin
                    position_count = position_count + COUNT_BITS'(longint'(s_word.count_step));
                end
            end
        end
        words_waiting <= expected_drive_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the encoder PID servo: drives words and registers, gives the verdict.
module tb_top
    import eps_pkg::*;
();

    localparam int DUTY_MAX          = 255;
    localparam int COUNT_BITS        = 32;
    localparam int CYCLE_LIMIT       = 600000;
    localparam int DRAIN_CYCLES      = 60;
    localparam int N_SETTINGS        = 7;
    localparam int ITEMS_PER_SETTING = 212;
    localparam int CONTROL_PCT       = 60;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_word;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int words_waiting;
    int cycle_count   = 0;
    int words_sent    = 0;
    int controls_sent = 0;
    int settings_used = 1;
    int cur_limit     = MAX_TARGET_RST;
    bit gaps_on       = 1'b1;

    encoder_pid_servo_core #(
        .DUTY_MAX   (DUTY_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    eps_servo_checker #(
        .DUTY_MAX   (DUTY_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_waiting (words_waiting)
    );

    // Clock with a period of 8.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL encoder_pid_servo_core");
        $finish;
    end

    // Result side: stalls a random number of cycles before taking each word.
    initial begin : result_sink
        int stall;
        forever begin
            stall = gaps_on ? $urandom_range(4, 0) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic in_word_t make_word(logic action, int step, int goal, int elapsed);
        in_word_t w;
        w.action     = action;
        w.count_step = 8'(step);
        w.target     = 16'(goal);
        w.elapsed_us = 16'(elapsed);
        return w;
    endfunction

    // Random word: targets near zero, inside the limit, at full scale, or anywhere.
    function automatic in_word_t random_word();
        in_word_t w;
        int       goal;
        int       elapsed;
        case ($urandom_range(3, 0))
            0: goal = int'($urandom_range(128, 0)) - 64;
            1: goal = int'($urandom_range(2 * cur_limit, 0)) - cur_limit;
            2: goal = $urandom_range(1, 0) ? 32767 : -32768;
            default: goal = int'($urandom_range(65535, 0)) - 32768;
        endcase
        case ($urandom_range(3, 0))
            0: elapsed = $urandom_range(16, 1);
            1: elapsed = $urandom_range(2000, 100);
            2: elapsed = $urandom_range(1, 0) ? 65535 : 1;
            default: elapsed = $urandom_range(65535, 1);
        endcase
        w = make_word(($urandom_range(99, 0) < CONTROL_PCT) ? ACT_CONTROL : ACT_ENCODER,
                      int'($urandom_range(255, 0)) - 128, goal, elapsed);
        return w;
    endfunction

    // Offer one input word after a random gap and hold it until it is taken.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = gaps_on ? $urandom_range(4, 0) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (w.action == ACT_CONTROL) controls_sent++;
    endtask

    // Wait until every drive word has arrived and any trailing encoder step is done.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers back to back, keeping the write channel valid between them.
    task automatic apply_setting(input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd, input logic [14:0] lim);
        logic [1:0]  reg_idx[4];
        logic [15:0] reg_val[4];
        reg_idx[0] = CFG_GAIN_PROP;
        reg_idx[1] = CFG_GAIN_INTEG;
        reg_idx[2] = CFG_GAIN_DERIV;
        reg_idx[3] = CFG_MAX_TARGET;
        reg_val[0] = kp;
        reg_val[1] = ki;
        reg_val[2] = kd;
        reg_val[3] = {1'b0, lim};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx[i];
            cfg_data  <= reg_val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_limit = lim;
        settings_used++;
    endtask

    // Main stimulus: reset, directed words at reset gains, then random phases.
    initial begin : stimulus
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [14:0] lim;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_word    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_GAIN_PROP;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: step and target extremes, unused fields set, both limits of the interval.
        send_word(make_word(ACT_CONTROL, 0, 0, 1));
        send_word(make_word(ACT_ENCODER, 127, 32767, 65535));
        send_word(make_word(ACT_ENCODER, -128, -32768, 1));
        send_word(make_word(ACT_ENCODER, 0, 0, 0));
        send_word(make_word(ACT_CONTROL, -128, 32767, 65535));
        send_word(make_word(ACT_CONTROL, 127, -32768, 1));
        send_word(make_word(ACT_CONTROL, 0, 500, 1000));
        send_word(make_word(ACT_CONTROL, -1, -1000, 65535));
        repeat (6) send_word(make_word(ACT_ENCODER, 127, -1, 65535));
        send_word(make_word(ACT_CONTROL, 0, 0, 1));
        send_word(make_word(ACT_CONTROL, 0, 1000, 1));
        repeat (8) send_word(make_word(ACT_ENCODER, -128, 0, 1));
        send_word(make_word(ACT_CONTROL, 55, -32768, 2));
        send_word(make_word(ACT_CONTROL, 0, 1, 65535));

        // Random phases, each under its own register setting.
        for (int p = 0; p < N_SETTINGS; p++) begin
            settle();
            case (p)
                0: begin kp = 16'hFFFF; ki = 16'hFFFF; kd = 16'hFFFF; lim = 15'h7FFF; end
                1: begin kp = 16'd0;    ki = 16'd0;    kd = 16'd0;    lim = 15'd0;    end
                2: begin kp = 16'd16;   ki = 16'd0;    kd = 16'd8;    lim = 15'd200;  end
                3: begin
                    kp  = $urandom_range(65535, 0);
                    ki  = $urandom_range(65535, 0);
                    kd  = $urandom_range(65535, 0);
                    lim = $urandom_range(32767, 0);
                end
                4: begin kp = 16'd256;  ki = 16'd0;    kd = 16'd0;    lim = 15'd5;    end
                5: begin
                    kp  = $urandom_range(300, 0);
                    ki  = $urandom_range(2, 0);
                    kd  = $urandom_range(300, 0);
                    lim = $urandom_range(32767, 0);
                end
                default: begin
                    kp = GAIN_PROP_RST; ki = GAIN_INTEG_RST; kd = GAIN_DERIV_RST;
                    lim = MAX_TARGET_RST;
                end
            endcase
            apply_setting(kp, ki, kd, lim);
            for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
                // Occasional stretches where neither side idles.
                if (i % 50 == 0) gaps_on = ($urandom_range(3, 0) != 0);
                send_word(random_word());
            end
        end

        gaps_on = 1'b1;
        settle();
        $display("Sent %0d words (%0d control updates) under %0d register settings.",
                 words_sent, controls_sent, settings_used);
        $display("Gains and target limit ran from zero to full scale with random idling.");
        if (fail_count == 0 && words_waiting == 0) begin
            $display("PASS encoder_pid_servo_core");
        end else begin
            $display("FAIL encoder_pid_servo_core");
        end
        $finish;
    end

endmodule
